// ===== rtl/sgbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgbm_pkg: shared constants and types of the stereo gain/balance mixer
// Register indexes, configuration limits and the multiplier status bundle.
// ----------------------------------------------------------------------------
package sgbm_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEFF_FRAC_DEF  = 29;
	localparam int MUL_FRAC_MAX    = 29;

	localparam int DIG_W       = 4;
	localparam int GLIDE_SHIFT = 16;

	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_PAN    = 3'd1;
	localparam logic [IDX_W-1:0] REG_MONO   = 3'd2;
	localparam logic [IDX_W-1:0] REG_PHASE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SMOOTH = 3'd4;

	localparam logic [CFG_W-1:0]        GAIN_MAX   = 16'd32768;
	localparam logic [CFG_W-1:0]        GAIN_RST   = 16'd16384;
	localparam logic [CFG_W-1:0]        SMOOTH_RST = 16'd272;
	localparam logic signed [CFG_W-1:0] PAN_MAX    = 16'sd16384;
	localparam logic signed [CFG_W-1:0] PAN_MIN    = -16'sd16384;

	localparam int UNITY_Q14 = 16384;
	localparam int BAL_W     = 15;
	localparam int MAG_W     = CFG_W + BAL_W;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sgbm_serial_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgbm_serial_mul: digit-serial signed multiplier
// Scans the multiplier operand one digit per cycle, top digit first (signed),
// and shifts the partial sum left by one digit each step.
// ----------------------------------------------------------------------------
module sgbm_serial_mul import sgbm_pkg::*; #(
	parameter int AW = 33,
	parameter int BW = 24
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [AW-1:0]   a,
	input  wire logic [BW-1:0]   b,
	output logic      [AW+BW-1:0] prod,
	output mul_stat_t            stat
);

	localparam int PW    = AW + BW;
	localparam int NDIG  = BW / DIG_W;
	localparam int CNT_W = $clog2(NDIG);

	logic [AW-1:0]    a_q;
	logic [BW-1:0]    b_q;
	logic [PW-1:0]    acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             last_step;

	logic signed [DIG_W:0]    dig;
	logic signed [AW+DIG_W:0] part;
	logic [PW-1:0]            acc_nx;

	always_comb begin
		if (cnt_q == '0) begin
			dig = $signed({b_q[BW-1], b_q[BW-1 -: DIG_W]});
		end else begin
			dig = $signed({1'b0, b_q[BW-1 -: DIG_W]});
		end
		part   = $signed(a_q) * dig;
		acc_nx = (acc_q << DIG_W) + PW'(part);
	end

	assign last_step = (cnt_q == CNT_W'(NDIG - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			done_q <= last_step;
			cnt_q  <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << DIG_W;
			acc_q <= acc_nx;
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

// ===== rtl/sgbm_target.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgbm_target: configuration registers and target coefficient matrix
// Holds gain, balance, mono, polarity and smoothing factor; derives the four
// target coefficients in signed Q2.COEFF_FRAC_BITS, registered.
// ----------------------------------------------------------------------------
module sgbm_target import sgbm_pkg::*; #(
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [IDX_W-1:0]            wr_idx,
	input  wire logic [CFG_W-1:0]            wr_data,
	output logic [3:0][COEFF_FRAC_BITS+2:0]  tgt,
	output logic [CFG_W-1:0]                 coeff
);

	localparam int CW     = COEFF_FRAC_BITS + 3;
	localparam int ES     = COEFF_FRAC_BITS - 28;
	localparam int EM     = COEFF_FRAC_BITS - 29;
	localparam int SHL_S  = (ES > 0) ? ES : 0;
	localparam int SHR_S  = (ES < 0) ? -ES : 0;
	localparam int SHL_M  = (EM > 0) ? EM : 0;
	localparam int SHR_M  = (EM < 0) ? -EM : 0;
	localparam int XW     = MAG_W + SHL_S;
	localparam logic [XW-1:0] RND_S = (XW'(1) << SHR_S) >> 1;
	localparam logic [XW-1:0] RND_M = (XW'(1) << SHR_M) >> 1;
	localparam logic [CW-1:0] ONE   = CW'(1) << COEFF_FRAC_BITS;

	logic [CFG_W-1:0]        gain_q;
	logic signed [CFG_W-1:0] pan_q;
	logic                    mono_q;
	logic                    inv_q;
	logic [CFG_W-1:0]        coeff_q;
	logic [3:0][CW-1:0]      tgt_q;

	logic signed [CFG_W-1:0] pan_in;
	logic [BAL_W-1:0]        bal_l, bal_r;
	logic [MAG_W-1:0]        mag_l, mag_r;
	logic [XW-1:0]           sc_ls, sc_lm, sc_rs, sc_rm;
	logic [CW-1:0]           m_ls, m_lm, m_rs, m_rm;
	logic [CW-1:0]           t_ls, t_lm, t_rs, t_rm;
	logic [3:0][CW-1:0]      tgt_d;

	assign pan_in = $signed(wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			pan_q   <= '0;
			mono_q  <= 1'b0;
			inv_q   <= 1'b0;
			coeff_q <= SMOOTH_RST;
		end else if (wr_en) begin
			case (wr_idx)
				REG_GAIN: begin
					gain_q <= (wr_data > GAIN_MAX) ? GAIN_MAX : wr_data;
				end
				REG_PAN: begin
					if (pan_in > PAN_MAX) begin
						pan_q <= PAN_MAX;
					end else if (pan_in < PAN_MIN) begin
						pan_q <= PAN_MIN;
					end else begin
						pan_q <= pan_in;
					end
				end
				REG_MONO: begin
					mono_q <= wr_data[0];
				end
				REG_PHASE: begin
					inv_q <= wr_data[0];
				end
				REG_SMOOTH: begin
					coeff_q <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		bal_l = (pan_q > 0) ? BAL_W'(UNITY_Q14 - pan_q) : BAL_W'(UNITY_Q14);
		bal_r = (pan_q < 0) ? BAL_W'(UNITY_Q14 + pan_q) : BAL_W'(UNITY_Q14);
		mag_l = MAG_W'(gain_q) * MAG_W'(bal_l);
		mag_r = MAG_W'(gain_q) * MAG_W'(bal_r);

		// magnitudes are non-negative, so half-up is half away from zero
		sc_ls = ((XW'(mag_l) << SHL_S) + RND_S) >> SHR_S;
		sc_lm = ((XW'(mag_l) << SHL_M) + RND_M) >> SHR_M;
		sc_rs = ((XW'(mag_r) << SHL_S) + RND_S) >> SHR_S;
		sc_rm = ((XW'(mag_r) << SHL_M) + RND_M) >> SHR_M;
		m_ls  = CW'(sc_ls);
		m_lm  = CW'(sc_lm);
		m_rs  = CW'(sc_rs);
		m_rm  = CW'(sc_rm);

		t_ls = inv_q ? -m_ls : m_ls;
		t_lm = inv_q ? -m_lm : m_lm;
		t_rs = inv_q ? -m_rs : m_rs;
		t_rm = inv_q ? -m_rm : m_rm;

		tgt_d[0] = mono_q ? t_lm : t_ls;
		tgt_d[1] = mono_q ? t_lm : '0;
		tgt_d[2] = mono_q ? t_rm : '0;
		tgt_d[3] = mono_q ? t_rm : t_rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q[0] <= ONE;
			tgt_q[1] <= '0;
			tgt_q[2] <= '0;
			tgt_q[3] <= ONE;
		end else begin
			tgt_q <= tgt_d;
		end
	end

	assign tgt   = tgt_q;
	assign coeff = coeff_q;

endmodule
`default_nettype wire

// ===== rtl/stereo_gain_balance_mixer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_gain_balance_mixer_core: stereo gain, balance and mono mixer
// 2x2 coefficient matrix with one-pole smoothed coefficients and saturated
// SAMPLE_BITS-wide outputs, built around one shared digit-serial multiplier.
//
//  channel   dir   signals                            content
//  s_*       in    s_tvalid/s_tready/s_tdata/s_tuser   frame or snap request
//                  s_tlast                            block end marker
//  m_*       out   m_tvalid/m_tready/m_tdata/m_tlast   mixed frame
//  wr_*      in    wr_en/wr_idx/wr_data                register write
//
// A frame runs four smoother steps and then four sample products on the
// shared multiplier, each of N = ceil(max(SAMPLE_BITS, 17) / 4) digits.
// A snap loads the smoothers with the current targets.
// Reset loads the smoothers with the reset targets (unity diagonal).
// A stalled m side holds the finished beat; the next beat is still taken
// and processed, and waits only to be written out.
// ----------------------------------------------------------------------------
module stereo_gain_balance_mixer_core import sgbm_pkg::*; #(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// in_left, in_right, zero pad
	input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
	// req_type
	input  wire logic                                 s_tuser,
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// out_left, out_right, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_tdata,
	output logic                                      m_tlast,
	input  wire logic                                 wr_en,
	input  wire logic [IDX_W-1:0]                     wr_idx,
	input  wire logic [CFG_W-1:0]                     wr_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int CFB    = COEFF_FRAC_BITS;
	localparam int DW     = ((2*SB+7)/8)*8;
	localparam int CW     = CFB + 3;
	localparam int MF     = (CFB > MUL_FRAC_MAX) ? MUL_FRAC_MAX : CFB;
	localparam int TS     = CFB - MF;
	localparam int MW     = MF + 3;
	localparam int AW     = CW + 1;
	localparam int BMIN   = (SB > CFG_W + 1) ? SB : CFG_W + 1;
	localparam int BW     = ((BMIN + DIG_W - 1) / DIG_W) * DIG_W;
	localparam int PW     = AW + BW;
	localparam int SW     = PW + 1;
	localparam int RW     = SW - MF;

	localparam logic [CW:0]   TM_RND = ((CW+1)'(1) << TS) >> 1;
	localparam bit            TM_ON  = (TS > 0);
	localparam logic [PW-1:0] G_RND  = PW'(1) << (GLIDE_SHIFT - 1);
	localparam logic [SW-1:0] M_RND  = SW'(1) << (MF - 1);
	localparam logic [CW-1:0] ONE    = CW'(1) << CFB;
	localparam logic signed [RW-1:0] SMAX = RW'((longint'(1) << (SB - 1)) - 1);
	localparam logic signed [RW-1:0] SMIN = RW'(-(longint'(1) << (SB - 1)));

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SNAP,
		ST_GGO,
		ST_GWAIT,
		ST_MGO,
		ST_MWAIT,
		ST_RND,
		ST_SAT,
		ST_PUSH
	} state_t;

	state_t             state_q;
	logic [1:0]         idx_q;
	logic [3:0][CW-1:0] s_q;
	logic               m_tvalid_q;

	logic signed [SB-1:0] lft_q, rgt_q;
	logic                 last_q;
	logic [SW-1:0]        acc_q;
	logic signed [RW-1:0] rnd_q;
	logic [SB-1:0]        res_l_q, res_r_q;
	logic [2*SB-1:0]      m_data_q;
	logic                 m_last_q;

	logic [3:0][CW-1:0] tgt;
	logic [CFG_W-1:0]   coeff;

	logic               accept;
	logic               out_free;
	logic [CW-1:0]      s_cur, t_cur;
	logic signed [AW-1:0] diff;
	logic [CW:0]        mc_w;
	logic signed [MW-1:0] mc;
	logic               mul_start;
	logic [AW-1:0]      mul_a;
	logic [BW-1:0]      mul_b;
	logic [PW-1:0]      prod;
	mul_stat_t          mstat;
	logic [PW-1:0]      g_w;
	logic signed [PW-1:0] step;
	logic [CW-1:0]      s_new;
	logic [SW-1:0]      p_ext;
	logic [SW-1:0]      r_w;
	logic signed [SW-1:0] r_sh;
	logic [SB-1:0]      sat;

	sgbm_target #(
		.COEFF_FRAC_BITS(CFB)
	) u_target (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_data(wr_data),
		.tgt    (tgt),
		.coeff  (coeff)
	);

	sgbm_serial_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.prod  (prod),
		.stat  (mstat)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		s_cur = s_q[idx_q];
		t_cur = tgt[idx_q];
		diff  = $signed({t_cur[CW-1], t_cur}) - $signed({s_cur[CW-1], s_cur});

		// coefficient rounded to the multiply precision
		mc_w = {s_cur[CW-1], s_cur} + TM_RND - (CW+1)'(TM_ON && s_cur[CW-1]);
		mc   = MW'($signed(mc_w) >>> TS);

		mul_start = (state_q == ST_GGO) || (state_q == ST_MGO);
		if (state_q == ST_GGO) begin
			mul_a = diff;
			mul_b = BW'(coeff);
		end else begin
			mul_a = AW'(mc);
			mul_b = idx_q[0] ? BW'(rgt_q) : BW'(lft_q);
		end

		g_w   = prod + G_RND - PW'(prod[PW-1]);
		step  = $signed(g_w) >>> GLIDE_SHIFT;
		s_new = s_cur + step[CW-1:0];

		p_ext = SW'($signed(prod));
		r_w   = acc_q + M_RND - SW'(acc_q[SW-1]);
		r_sh  = $signed(r_w) >>> MF;

		if (rnd_q > SMAX) begin
			sat = SMAX[SB-1:0];
		end else if (rnd_q < SMIN) begin
			sat = SMIN[SB-1:0];
		end else begin
			sat = rnd_q[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
			s_q[0]     <= ONE;
			s_q[1]     <= '0;
			s_q[2]     <= '0;
			s_q[3]     <= ONE;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_PUSH) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= s_tuser ? ST_SNAP : ST_GGO;
					end
				end
				ST_SNAP: begin
					s_q     <= tgt;
					state_q <= ST_IDLE;
				end
				ST_GGO: begin
					state_q <= ST_GWAIT;
				end
				ST_GWAIT: begin
					if (mstat.done) begin
						s_q[idx_q] <= s_new;
						idx_q      <= idx_q + 1'b1;
						state_q    <= (idx_q == 2'd3) ? ST_MGO : ST_GGO;
					end
				end
				ST_MGO: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mstat.done) begin
						if (idx_q[0]) begin
							state_q <= ST_RND;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_MGO;
						end
					end
				end
				ST_RND: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == 2'd3) ? ST_PUSH : ST_MGO;
				end
				ST_PUSH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lft_q  <= $signed(s_tdata[SB-1:0]);
			rgt_q  <= $signed(s_tdata[2*SB-1:SB]);
			last_q <= s_tlast;
		end
		if (state_q == ST_MWAIT && mstat.done) begin
			acc_q <= idx_q[0] ? acc_q + p_ext : p_ext;
		end
		if (state_q == ST_RND) begin
			rnd_q <= RW'(r_sh);
		end
		if (state_q == ST_SAT) begin
			if (idx_q[1]) begin
				res_r_q <= sat;
			end else begin
				res_l_q <= sat;
			end
		end
		if (state_q == ST_PUSH && out_free) begin
			m_data_q <= {res_r_q, res_l_q};
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DW'(m_data_q);
	assign m_tlast  = m_last_q;

	a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mstat.busy)
		else $error("multiplier started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |-> (state_q == ST_GWAIT || state_q == ST_MWAIT))
		else $error("multiplier result outside a wait state");

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_PUSH))
		else $error("output beat raised outside push");

	a_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.busy |-> (state_q == ST_GWAIT || state_q == ST_MWAIT))
		else $error("multiplier running outside a wait state");

endmodule
`default_nettype wire
